[rtl/core/mpid_pkg.sv]
// Package for the multi-mode positional PID block.
// Holds field widths, register codes, mode codes, reset values and stage structs.
// No dependencies; every other file of the block uses it.
package mpid_pkg;

    // Field widths.
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned ERR_W    = 17;
    localparam int unsigned DELTA_W  = 18;
    localparam int unsigned SUM_W    = 32;
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned LIMIT_W  = 15;
    localparam int unsigned IL_W     = 31;
    localparam int unsigned DRIVE_W  = 16;

    // Products of an unsigned gain with a signed operand.
    localparam int unsigned PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int unsigned PROD_I_W = GAIN_W + 1 + SUM_W;
    localparam int unsigned PROD_D_W = GAIN_W + 1 + DELTA_W;

    // Q8.8 gains: scaled terms drop eight fraction bits.
    localparam int unsigned FRAC_W   = 8;
    localparam int unsigned TERM_P_W = PROD_P_W - FRAC_W;
    localparam int unsigned TERM_I_W = PROD_I_W - FRAC_W;
    localparam int unsigned TERM_D_W = PROD_D_W - FRAC_W;
    localparam int unsigned TOTAL_W  = TERM_I_W + 1;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = IL_W;

    // Reset values of the limit registers.
    localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST    = {LIMIT_W{1'b1}};
    localparam logic [LIMIT_W-1:0] TERM_LIMIT_RST     = {LIMIT_W{1'b1}};
    localparam logic [IL_W-1:0]    INTEGRAL_LIMIT_RST = {IL_W{1'b1}};

    // Controller modes.
    typedef enum logic [1:0] {
        MODE_PLAIN       = 2'd0,
        MODE_SEPARATED   = 2'd1,
        MODE_ANTI_WINDUP = 2'd2,
        MODE_WEAKENED    = 2'd3
    } t_mode;

    // Register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE           = 3'd0,
        REG_GAIN_P         = 3'd1,
        REG_GAIN_I         = 3'd2,
        REG_GAIN_D         = 3'd3,
        REG_DRIVE_LIMIT    = 3'd4,
        REG_DEAD_BAND      = 3'd5,
        REG_INTEGRAL_LIMIT = 3'd6,
        REG_TERM_LIMIT     = 3'd7
    } t_reg_idx;

    // Register file contents.
    typedef struct packed {
        t_mode                mode;
        logic [GAIN_W-1:0]    gain_p;
        logic [GAIN_W-1:0]    gain_i;
        logic [GAIN_W-1:0]    gain_d;
        logic [LIMIT_W-1:0]   drive_limit;
        logic [GAIN_W-1:0]    dead_band;
        logic [IL_W-1:0]      integral_limit;
        logic [LIMIT_W-1:0]   term_limit;
    } t_cfg;

    // Error stage: error used, integral for the I term, error difference.
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [SUM_W-1:0]   sum_i;
        logic signed [DELTA_W-1:0] delta;
        logic                      i_off;
        logic                      clip;
    } t_err_stage;

    // Product stage.
    typedef struct packed {
        logic signed [ERR_W-1:0]    err;
        logic signed [PROD_P_W-1:0] prod_p;
        logic signed [PROD_I_W-1:0] prod_i;
        logic signed [PROD_D_W-1:0] prod_d;
        logic                       i_off;
        logic                       clip;
    } t_prod_stage;

    // Scaled and clipped term stage.
    typedef struct packed {
        logic signed [ERR_W-1:0]    err;
        logic signed [TERM_P_W-1:0] term_p;
        logic signed [TERM_I_W-1:0] term_i;
        logic signed [TERM_D_W-1:0] term_d;
    } t_term_stage;

endpackage

[rtl/core/mpid_if.sv]
// Channel interfaces of the multi-mode positional PID block.
// Sample input, result output and configuration write channels.
// Depends on mpid_pkg for field widths.
interface mpid_in_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [mpid_pkg::SAMPLE_W-1:0]       target;
    logic signed [mpid_pkg::SAMPLE_W-1:0]       feedback;

    modport source (output valid, output target, output feedback, input ready);
    modport sink   (input valid, input target, input feedback, output ready);
endinterface

interface mpid_out_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [mpid_pkg::DRIVE_W-1:0]        drive;
    logic signed [mpid_pkg::ERR_W-1:0]          error_out;

    modport source (output valid, output drive, output error_out, input ready);
    modport sink   (input valid, input drive, input error_out, output ready);
endinterface

interface mpid_cfg_if;
    logic                                       valid;
    logic                                       ready;
    logic [mpid_pkg::CFG_IDX_W-1:0]             index;
    logic [mpid_pkg::CFG_DATA_W-1:0]            data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/multi_mode_positional_pid_top.sv]
// Top level of the multi-mode positional PID block.
// Holds the register file and the input register and chains the four stages.
// Depends on mpid_pkg, the channel interfaces and the mpid_* stage modules.
//
//   Channel    Direction  Payload                       Role
//   i_in_ch    sink       target, feedback (s16 each)   one sample item per step
//   o_out_ch   source     drive (s16), error_out (s17)  one result item per sample
//   i_cfg_ch   sink       index (3), data (31)          register writes, always ready
//
// One item is taken per cycle while no result is held; a result passes the input register,
// error stage, multiply stage, scale stage and output register before it leaves.
// The integral and last error update in the error stage, once per item.
// A held result (valid without ready) freezes every stage and lowers i_in_ch.ready.
// Reset clears the valid bits, the integral sum and the last error and loads the register reset values.
module multi_mode_positional_pid_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mpid_in_if.sink     i_in_ch,
    mpid_out_if.source  o_out_ch,
    mpid_cfg_if.sink    i_cfg_ch
);

    logic                                r_in_valid;
    logic signed [mpid_pkg::SAMPLE_W-1:0] r_target;
    logic signed [mpid_pkg::SAMPLE_W-1:0] r_feedback;
    mpid_pkg::t_cfg                      r_cfg;

    logic                  en;
    logic                  err_valid;
    mpid_pkg::t_err_stage  err_stage;
    logic                  prod_valid;
    mpid_pkg::t_prod_stage prod_stage;
    logic                  term_valid;
    mpid_pkg::t_term_stage term_stage;

    // The whole pipeline moves unless a result is waiting to be taken.
    assign en             = !o_out_ch.valid || o_out_ch.ready;
    assign i_in_ch.ready  = en;
    assign i_cfg_ch.ready = 1'b1;

    // Register file; each register keeps its own width of the write data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= mpid_pkg::MODE_PLAIN;
            r_cfg.gain_p         <= '0;
            r_cfg.gain_i         <= '0;
            r_cfg.gain_d         <= '0;
            r_cfg.drive_limit    <= mpid_pkg::DRIVE_LIMIT_RST;
            r_cfg.dead_band      <= '0;
            r_cfg.integral_limit <= mpid_pkg::INTEGRAL_LIMIT_RST;
            r_cfg.term_limit     <= mpid_pkg::TERM_LIMIT_RST;
        end else if (i_cfg_ch.valid) begin
            case (mpid_pkg::t_reg_idx'(i_cfg_ch.index))
                mpid_pkg::REG_MODE: begin
                    r_cfg.mode <= mpid_pkg::t_mode'(i_cfg_ch.data[1:0]);
                end
                mpid_pkg::REG_GAIN_P: begin
                    r_cfg.gain_p <= i_cfg_ch.data[mpid_pkg::GAIN_W-1:0];
                end
                mpid_pkg::REG_GAIN_I: begin
                    r_cfg.gain_i <= i_cfg_ch.data[mpid_pkg::GAIN_W-1:0];
                end
                mpid_pkg::REG_GAIN_D: begin
                    r_cfg.gain_d <= i_cfg_ch.data[mpid_pkg::GAIN_W-1:0];
                end
                mpid_pkg::REG_DRIVE_LIMIT: begin
                    r_cfg.drive_limit <= i_cfg_ch.data[mpid_pkg::LIMIT_W-1:0];
                end
                mpid_pkg::REG_DEAD_BAND: begin
                    r_cfg.dead_band <= i_cfg_ch.data[mpid_pkg::GAIN_W-1:0];
                end
                mpid_pkg::REG_INTEGRAL_LIMIT: begin
                    r_cfg.integral_limit <= i_cfg_ch.data[mpid_pkg::IL_W-1:0];
                end
                mpid_pkg::REG_TERM_LIMIT: begin
                    r_cfg.term_limit <= i_cfg_ch.data[mpid_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_target   <= i_in_ch.target;
            r_feedback <= i_in_ch.feedback;
        end
    end

    // Error and integral stage.
    mpid_state u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_in_valid),
        .i_target   (r_target),
        .i_feedback (r_feedback),
        .i_cfg      (r_cfg),
        .o_valid    (err_valid),
        .o_stage    (err_stage)
    );

    // Gain products.
    mpid_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (err_valid),
        .i_stage (err_stage),
        .i_cfg   (r_cfg),
        .o_valid (prod_valid),
        .o_stage (prod_stage)
    );

    // Fraction drop and term clipping.
    mpid_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (prod_valid),
        .i_stage (prod_stage),
        .i_cfg   (r_cfg),
        .o_valid (term_valid),
        .o_stage (term_stage)
    );

    // Sum, drive clamp and output register.
    mpid_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (term_valid),
        .i_stage (term_stage),
        .i_cfg   (r_cfg),
        .o_valid (o_out_ch.valid),
        .o_drive (o_out_ch.drive),
        .o_err   (o_out_ch.error_out)
    );

endmodule

[rtl/core/mpid_state.sv]
// Error and integral stage of the multi-mode positional PID block.
// Forms the error, updates the integral sum and last error, registers the result.
// Depends on mpid_pkg.
module mpid_state (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic signed [mpid_pkg::SAMPLE_W-1:0]  i_target,
    input  logic signed [mpid_pkg::SAMPLE_W-1:0]  i_feedback,
    input  mpid_pkg::t_cfg                        i_cfg,
    output logic                                  o_valid,
    output mpid_pkg::t_err_stage                  o_stage
);

    logic signed [mpid_pkg::SUM_W-1:0]   r_sum;
    logic signed [mpid_pkg::SUM_W-1:0]   n_sum;
    logic signed [mpid_pkg::ERR_W-1:0]   r_last;
    logic                                r_valid;
    mpid_pkg::t_err_stage                r_stage;
    mpid_pkg::t_err_stage                n_stage;

    logic signed [mpid_pkg::ERR_W-1:0]   err_raw;
    logic        [mpid_pkg::ERR_W-1:0]   err_abs;
    logic        [mpid_pkg::ERR_W-1:0]   abs_use;
    logic signed [mpid_pkg::ERR_W-1:0]   err_use;
    logic        [mpid_pkg::ERR_W-1:0]   db_ext;
    logic                                band_le;
    logic                                band_lt;
    logic                                plain_mode;
    logic                                anti_mode;
    logic signed [mpid_pkg::SUM_W:0]     sum_add;
    logic signed [mpid_pkg::SUM_W:0]     sum_pre;
    logic signed [mpid_pkg::SUM_W:0]     il_ext;
    logic signed [mpid_pkg::SUM_W-1:0]   sum_sat;
    logic signed [mpid_pkg::SUM_W-1:0]   sum_clip;
    logic signed [mpid_pkg::SUM_W-1:0]   sum_i;

    // Error and its magnitude against the dead band.
    always_comb begin
        err_raw    = {i_target[mpid_pkg::SAMPLE_W-1], i_target}
                   - {i_feedback[mpid_pkg::SAMPLE_W-1], i_feedback};
        err_abs    = err_raw[mpid_pkg::ERR_W-1] ? (-err_raw) : err_raw;
        db_ext     = {1'b0, i_cfg.dead_band};
        band_le    = (err_abs <= db_ext);
        band_lt    = (err_abs < db_ext);
        plain_mode = (i_cfg.mode == mpid_pkg::MODE_PLAIN)
                  || (i_cfg.mode == mpid_pkg::MODE_SEPARATED);
        anti_mode  = (i_cfg.mode == mpid_pkg::MODE_ANTI_WINDUP);
        // Only the plain modes zero the error inside the dead band.
        if (plain_mode && band_le) begin
            err_use = '0;
            abs_use = '0;
        end else begin
            err_use = err_raw;
            abs_use = err_abs;
        end
    end

    // Integral update: saturation in the plain modes, clip to the limit otherwise.
    always_comb begin
        sum_add = {r_sum[mpid_pkg::SUM_W-1], r_sum}
                + {{(mpid_pkg::SUM_W + 1 - mpid_pkg::ERR_W){err_use[mpid_pkg::ERR_W-1]}},
                   err_use};
        if (sum_add[mpid_pkg::SUM_W] != sum_add[mpid_pkg::SUM_W-1]) begin
            sum_sat = sum_add[mpid_pkg::SUM_W] ? {1'b1, {(mpid_pkg::SUM_W-1){1'b0}}}
                                               : {1'b0, {(mpid_pkg::SUM_W-1){1'b1}}};
        end else begin
            sum_sat = sum_add[mpid_pkg::SUM_W-1:0];
        end
        // The weakened mode integrates only errors inside the window.
        if (anti_mode || band_lt) begin
            sum_pre = sum_add;
        end else begin
            sum_pre = {r_sum[mpid_pkg::SUM_W-1], r_sum};
        end
        il_ext = $signed({2'b00, i_cfg.integral_limit});
        if (sum_pre >= il_ext) begin
            sum_clip = il_ext[mpid_pkg::SUM_W-1:0];
        end else if (sum_pre <= -il_ext) begin
            sum_clip = -$signed(il_ext[mpid_pkg::SUM_W-1:0]);
        end else begin
            sum_clip = sum_pre[mpid_pkg::SUM_W-1:0];
        end
        sum_i = plain_mode ? sum_sat : sum_clip;
        // Anti-windup resets the stored sum inside the dead band.
        n_sum = (anti_mode && band_lt) ? '0 : sum_i;
    end

    // Stage payload.
    always_comb begin
        n_stage.err   = err_use;
        n_stage.sum_i = sum_i;
        n_stage.delta = {err_use[mpid_pkg::ERR_W-1], err_use}
                      - {r_last[mpid_pkg::ERR_W-1], r_last};
        n_stage.i_off = (i_cfg.mode == mpid_pkg::MODE_SEPARATED)
                     && ({{(mpid_pkg::SUM_W - mpid_pkg::ERR_W){1'b0}}, abs_use}
                         > {1'b0, i_cfg.integral_limit});
        n_stage.clip  = !plain_mode;
    end

    // Controller state advances once per item leaving this stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_last  <= '0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_sum  <= n_sum;
                r_last <= err_use;
            end
        end
    end

    // Stage register payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

[rtl/core/mpid_mult.sv]
// Multiply stage of the multi-mode positional PID block.
// Three gain products, registered.
// Depends on mpid_pkg.
module mpid_mult (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  mpid_pkg::t_err_stage  i_stage,
    input  mpid_pkg::t_cfg        i_cfg,
    output logic                  o_valid,
    output mpid_pkg::t_prod_stage o_stage
);

    logic                  r_valid;
    mpid_pkg::t_prod_stage r_stage;
    mpid_pkg::t_prod_stage n_stage;

    // Gains are unsigned: a zero sign bit makes them signed operands.
    always_comb begin
        n_stage.err    = i_stage.err;
        n_stage.prod_p = $signed({1'b0, i_cfg.gain_p}) * i_stage.err;
        n_stage.prod_i = $signed({1'b0, i_cfg.gain_i}) * i_stage.sum_i;
        n_stage.prod_d = $signed({1'b0, i_cfg.gain_d}) * i_stage.delta;
        n_stage.i_off  = i_stage.i_off;
        n_stage.clip   = i_stage.clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

[rtl/core/mpid_scale.sv]
// Scaling stage of the multi-mode positional PID block.
// Drops the Q8.8 fraction toward zero and clips the P and D terms in the clipping modes.
// Depends on mpid_pkg.
module mpid_scale (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  mpid_pkg::t_prod_stage i_stage,
    input  mpid_pkg::t_cfg        i_cfg,
    output logic                  o_valid,
    output mpid_pkg::t_term_stage o_stage
);

    localparam int unsigned PW = mpid_pkg::PROD_P_W;
    localparam int unsigned IW = mpid_pkg::PROD_I_W;
    localparam int unsigned DW = mpid_pkg::PROD_D_W;
    localparam int unsigned FW = mpid_pkg::FRAC_W;

    logic                  r_valid;
    mpid_pkg::t_term_stage r_stage;
    mpid_pkg::t_term_stage n_stage;

    logic signed [PW-1:0]                   p_bias;
    logic signed [IW-1:0]                   i_bias;
    logic signed [DW-1:0]                   d_bias;
    logic signed [mpid_pkg::TERM_P_W-1:0]   p_raw;
    logic signed [mpid_pkg::TERM_D_W-1:0]   d_raw;
    logic signed [mpid_pkg::TERM_P_W-1:0]   tl_p;
    logic signed [mpid_pkg::TERM_D_W-1:0]   tl_d;

    // A negative product gets a bias of one less than the scale, so the shift
    // rounds toward zero.
    always_comb begin
        p_bias = i_stage.prod_p + $signed({{(PW-FW){1'b0}}, {FW{i_stage.prod_p[PW-1]}}});
        i_bias = i_stage.prod_i + $signed({{(IW-FW){1'b0}}, {FW{i_stage.prod_i[IW-1]}}});
        d_bias = i_stage.prod_d + $signed({{(DW-FW){1'b0}}, {FW{i_stage.prod_d[DW-1]}}});
        p_raw  = p_bias[PW-1:FW];
        d_raw  = d_bias[DW-1:FW];
        tl_p   = $signed({{(mpid_pkg::TERM_P_W - mpid_pkg::LIMIT_W){1'b0}}, i_cfg.term_limit});
        tl_d   = $signed({{(mpid_pkg::TERM_D_W - mpid_pkg::LIMIT_W){1'b0}}, i_cfg.term_limit});
    end

    // Term clipping in the anti-windup and weakened modes.
    always_comb begin
        n_stage.err = i_stage.err;
        if (i_stage.clip && (p_raw > tl_p)) begin
            n_stage.term_p = tl_p;
        end else if (i_stage.clip && (p_raw < -tl_p)) begin
            n_stage.term_p = -tl_p;
        end else begin
            n_stage.term_p = p_raw;
        end
        if (i_stage.clip && (d_raw > tl_d)) begin
            n_stage.term_d = tl_d;
        end else if (i_stage.clip && (d_raw < -tl_d)) begin
            n_stage.term_d = -tl_d;
        end else begin
            n_stage.term_d = d_raw;
        end
        // Integral separation drops the I term for large errors.
        n_stage.term_i = i_stage.i_off ? '0 : i_bias[IW-1:FW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

[rtl/core/mpid_sum.sv]
// Output stage of the multi-mode positional PID block.
// Adds the three terms, clamps to the drive limit and holds the result item.
// Depends on mpid_pkg.
module mpid_sum (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  mpid_pkg::t_term_stage                i_stage,
    input  mpid_pkg::t_cfg                       i_cfg,
    output logic                                 o_valid,
    output logic signed [mpid_pkg::DRIVE_W-1:0]  o_drive,
    output logic signed [mpid_pkg::ERR_W-1:0]    o_err
);

    localparam int unsigned TW = mpid_pkg::TOTAL_W;

    logic                                r_valid;
    logic signed [mpid_pkg::DRIVE_W-1:0] r_drive;
    logic signed [mpid_pkg::ERR_W-1:0]   r_err;

    logic signed [TW-1:0]                total;
    logic signed [TW-1:0]                dl_ext;
    logic signed [TW-1:0]                total_clamp;

    // Exact sum of the terms, then the symmetric drive clamp.
    always_comb begin
        total = {{(TW - mpid_pkg::TERM_P_W){i_stage.term_p[mpid_pkg::TERM_P_W-1]}},
                 i_stage.term_p}
              + {{(TW - mpid_pkg::TERM_I_W){i_stage.term_i[mpid_pkg::TERM_I_W-1]}},
                 i_stage.term_i}
              + {{(TW - mpid_pkg::TERM_D_W){i_stage.term_d[mpid_pkg::TERM_D_W-1]}},
                 i_stage.term_d};
        dl_ext = $signed({{(TW - mpid_pkg::LIMIT_W){1'b0}}, i_cfg.drive_limit});
        if (total <= -dl_ext) begin
            total_clamp = -dl_ext;
        end else if (total >= dl_ext) begin
            total_clamp = dl_ext;
        end else begin
            total_clamp = total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_drive <= total_clamp[mpid_pkg::DRIVE_W-1:0];
            r_err   <= i_stage.err;
        end
    end

    assign o_valid = r_valid;
    assign o_drive = r_drive;
    assign o_err   = r_err;

endmodule

[rtl/core/mpid_checker.sv]
// Port-level checker for the multi-mode positional PID block, bound to the top level.
// Tracks the drive limit, dead band and mode from register writes.
// Depends on mpid_pkg and multi_mode_positional_pid_top.
module mpid_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_ready,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic signed [mpid_pkg::DRIVE_W-1:0]  i_drive,
    input  logic signed [mpid_pkg::ERR_W-1:0]    i_error_out,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [mpid_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mpid_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [mpid_pkg::LIMIT_W-1:0] r_dl;
    logic [mpid_pkg::GAIN_W-1:0]  r_db;
    logic                         r_plain;

    logic signed [mpid_pkg::ERR_W-1:0] dl_s;
    logic        [mpid_pkg::ERR_W-1:0] err_abs;

    // Shadow copies of the registers the checks depend on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl    <= mpid_pkg::DRIVE_LIMIT_RST;
            r_db    <= '0;
            r_plain <= 1'b1;
        end else if (i_cfg_valid && i_cfg_ready) begin
            if (i_cfg_index == mpid_pkg::REG_DRIVE_LIMIT) begin
                r_dl <= i_cfg_data[mpid_pkg::LIMIT_W-1:0];
            end
            if (i_cfg_index == mpid_pkg::REG_DEAD_BAND) begin
                r_db <= i_cfg_data[mpid_pkg::GAIN_W-1:0];
            end
            if (i_cfg_index == mpid_pkg::REG_MODE) begin
                r_plain <= (i_cfg_data[1:0] == mpid_pkg::MODE_PLAIN)
                        || (i_cfg_data[1:0] == mpid_pkg::MODE_SEPARATED);
            end
        end
    end

    assign dl_s    = $signed({{(mpid_pkg::ERR_W - mpid_pkg::LIMIT_W){1'b0}}, r_dl});
    assign err_abs = i_error_out[mpid_pkg::ERR_W-1] ? (-i_error_out) : i_error_out;

    // Input is taken exactly when the output side can move.
    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow the output handshake");

    // A result waiting to be taken holds still.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_drive) && $stable(i_error_out)))
        else $error("result item changed while stalled");

    // Drive stays within the configured limit.
    a_drive_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            ($signed({i_drive[mpid_pkg::DRIVE_W-1], i_drive}) <= dl_s)
            && ($signed({i_drive[mpid_pkg::DRIVE_W-1], i_drive}) >= -dl_s))
        else $error("drive outside the drive limit");

    // In the plain modes a nonzero error lies outside the dead band.
    a_dead_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && r_plain && (i_error_out != '0)) |->
            (err_abs > {1'b0, r_db}))
        else $error("nonzero error inside the dead band");

endmodule

bind multi_mode_positional_pid_top mpid_checker u_mpid_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in_ch.ready),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_drive     (o_out_ch.drive),
    .i_error_out (o_out_ch.error_out),
    .i_cfg_valid (i_cfg_ch.valid),
    .i_cfg_ready (i_cfg_ch.ready),
    .i_cfg_index (i_cfg_ch.index),
    .i_cfg_data  (i_cfg_ch.data)
);

[dv/multi_mode_positional_pid_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the multi-mode positional PID top level.
// Runs directed rows, random configuration phases and full-error integral runs
// against a predictor. Depends on mpid_pkg, the channel interfaces and the top level.
module multi_mode_positional_pid_top_tb;

    localparam int     STALL_CYCLES = 300;
    localparam int     RAND_PHASES  = 12;
    localparam int     PHASE_ITEMS  = 70;
    localparam int     WINDUP_ITEMS = 15;
    localparam int     SETTLE       = 20;
    localparam longint SUM_MAX      = 2147483647;
    localparam longint SUM_MIN      = -SUM_MAX - 1;

    typedef logic [mpid_pkg::CFG_DATA_W-1:0]      t_cfg_data;
    typedef logic signed [mpid_pkg::SAMPLE_W-1:0] t_sample;

    typedef struct {
        logic signed [mpid_pkg::DRIVE_W-1:0] drive;
        logic signed [mpid_pkg::ERR_W-1:0]   error_out;
    } t_pid_result;

    typedef enum {ROW_WRITE, ROW_SAMPLE} t_row_kind;

    typedef struct {
        t_row_kind           kind;
        mpid_pkg::t_reg_idx  idx;
        t_cfg_data           data;
        t_sample             tgt;
        t_sample             fbk;
        bit                  typed;
        t_pid_result         res;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    mpid_in_if  in_ch ();
    mpid_out_if out_ch ();
    mpid_cfg_if cfg_ch ();

    multi_mode_positional_pid_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .i_cfg_ch (cfg_ch)
    );

    // Predictor copy of the register file and the controller state.
    mpid_pkg::t_cfg pid_cfg;
    longint         integ_sum;
    longint         prev_error;
    t_pid_result    pid_result_q[$];
    t_dir_row       dir_rows[$];

    int fail_count;
    bit gaps_on;
    bit hold_req;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v <= lo) return lo;
        if (v >= hi) return hi;
        return v;
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Bits that a register keeps; the rest of the write data is dropped.
    function automatic t_cfg_data reg_mask(mpid_pkg::t_reg_idx idx);
        case (idx)
            mpid_pkg::REG_MODE:                  return 31'h3;
            mpid_pkg::REG_DRIVE_LIMIT,
            mpid_pkg::REG_TERM_LIMIT:            return 31'h7FFF;
            mpid_pkg::REG_INTEGRAL_LIMIT:        return 31'h7FFF_FFFF;
            default:                             return 31'hFFFF;
        endcase
    endfunction

    // Computes the result of one sample and advances the integral and last error.
    function automatic t_pid_result pid_advance(t_sample tgt, t_sample fbk);
        longint e, ae, db, il, tl, dl, s, p, i_term, d, u;
        t_pid_result res;
        e  = longint'(tgt) - longint'(fbk);
        ae = mag(e);
        db = longint'(pid_cfg.dead_band);
        il = longint'(pid_cfg.integral_limit);
        tl = longint'(pid_cfg.term_limit);
        dl = longint'(pid_cfg.drive_limit);
        s  = integ_sum;
        if (pid_cfg.mode == mpid_pkg::MODE_PLAIN
                || pid_cfg.mode == mpid_pkg::MODE_SEPARATED) begin
            // Dead band zeroes the error; the sum saturates at 32 bits.
            if (ae <= db) e = 0;
            s      = clip(s + e, SUM_MIN, SUM_MAX);
            p      = (longint'(pid_cfg.gain_p) * e) / 256;
            i_term = (longint'(pid_cfg.gain_i) * s) / 256;
            d      = (longint'(pid_cfg.gain_d) * (e - prev_error)) / 256;
            if (pid_cfg.mode == mpid_pkg::MODE_SEPARATED && mag(e) > il) i_term = 0;
        end else begin
            // Clipped integral and terms; anti-windup clears the sum inside the band.
            if (pid_cfg.mode == mpid_pkg::MODE_ANTI_WINDUP || ae < db) s = s + e;
            s      = clip(s, -il, il);
            i_term = (longint'(pid_cfg.gain_i) * s) / 256;
            p      = clip((longint'(pid_cfg.gain_p) * e) / 256, -tl, tl);
            d      = clip((longint'(pid_cfg.gain_d) * (e - prev_error)) / 256, -tl, tl);
            if (pid_cfg.mode == mpid_pkg::MODE_ANTI_WINDUP && ae < db) s = 0;
        end
        u          = clip(p + i_term + d, -dl, dl);
        integ_sum  = s;
        prev_error = e;
        res.drive     = u[mpid_pkg::DRIVE_W-1:0];
        res.error_out = e[mpid_pkg::ERR_W-1:0];
        return res;
    endfunction

    // Random register value: zero, the top, a small value or anything in range.
    function automatic t_cfg_data rand_pick(int unsigned small_max, int unsigned full_max);
        int unsigned sel;
        sel = $urandom_range(7);
        if (sel == 0) return '0;
        if (sel == 1) return t_cfg_data'(full_max);
        if (sel < 6)  return t_cfg_data'($urandom_range(small_max));
        return t_cfg_data'($urandom_range(full_max));
    endfunction

    function automatic void add_write(mpid_pkg::t_reg_idx idx, int value);
        t_dir_row row;
        row.kind            = ROW_WRITE;
        row.idx             = idx;
        row.data            = value[mpid_pkg::CFG_DATA_W-1:0];
        row.tgt             = '0;
        row.fbk             = '0;
        row.typed           = 1'b0;
        row.res.drive       = '0;
        row.res.error_out   = '0;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_sample(int tgt, int fbk);
        t_dir_row row;
        row.kind            = ROW_SAMPLE;
        row.idx             = mpid_pkg::REG_MODE;
        row.data            = '0;
        row.tgt             = tgt[mpid_pkg::SAMPLE_W-1:0];
        row.fbk             = fbk[mpid_pkg::SAMPLE_W-1:0];
        row.typed           = 1'b0;
        row.res.drive       = '0;
        row.res.error_out   = '0;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_typed(int tgt, int fbk, int drv, int err);
        t_dir_row row;
        row.kind            = ROW_SAMPLE;
        row.idx             = mpid_pkg::REG_MODE;
        row.data            = '0;
        row.tgt             = tgt[mpid_pkg::SAMPLE_W-1:0];
        row.fbk             = fbk[mpid_pkg::SAMPLE_W-1:0];
        row.typed           = 1'b1;
        row.res.drive       = drv[mpid_pkg::DRIVE_W-1:0];
        row.res.error_out   = err[mpid_pkg::ERR_W-1:0];
        dir_rows.push_back(row);
    endfunction

    // Lowers the sample valid and waits until every expected result has come.
    task automatic wait_results_done();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pid_result_q.size() != 0) @(posedge i_clk);
    endtask

    // Offers one sample item and records its expected result on acceptance.
    task automatic send_sample(t_sample tgt, t_sample fbk, bit typed,
                               t_pid_result typed_res);
        t_pid_result res;
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < 10) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.target   <= tgt;
        in_ch.feedback <= fbk;
        do @(posedge i_clk); while (!in_ch.ready);
        res = pid_advance(tgt, fbk);
        pid_result_q.push_back(typed ? typed_res : res);
    endtask

    // Writes one register once the block is idle; upper bits are sometimes junk.
    task automatic write_reg(mpid_pkg::t_reg_idx idx, t_cfg_data value);
        t_cfg_data data;
        t_cfg_data kept;
        data = value;
        if ($urandom_range(3) == 0) data = data | (~reg_mask(idx) & t_cfg_data'($urandom()));
        wait_results_done();
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        kept = data & reg_mask(idx);
        case (idx)
            mpid_pkg::REG_MODE:
                pid_cfg.mode           = mpid_pkg::t_mode'(kept[1:0]);
            mpid_pkg::REG_GAIN_P:
                pid_cfg.gain_p         = kept[mpid_pkg::GAIN_W-1:0];
            mpid_pkg::REG_GAIN_I:
                pid_cfg.gain_i         = kept[mpid_pkg::GAIN_W-1:0];
            mpid_pkg::REG_GAIN_D:
                pid_cfg.gain_d         = kept[mpid_pkg::GAIN_W-1:0];
            mpid_pkg::REG_DRIVE_LIMIT:
                pid_cfg.drive_limit    = kept[mpid_pkg::LIMIT_W-1:0];
            mpid_pkg::REG_DEAD_BAND:
                pid_cfg.dead_band      = kept[mpid_pkg::GAIN_W-1:0];
            mpid_pkg::REG_INTEGRAL_LIMIT:
                pid_cfg.integral_limit = kept[mpid_pkg::IL_W-1:0];
            default:
                pid_cfg.term_limit     = kept[mpid_pkg::LIMIT_W-1:0];
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result side: random back-pressure and one long hold-off on request.
    initial begin : result_ready
        int k;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                for (k = 1; k < STALL_CYCLES; k++) @(negedge i_clk);
            end else begin
                out_ch.ready <= !(gaps_on && $urandom_range(99) < 10);
            end
        end
    end

    // Each accepted result is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_pid_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pid_result_q.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected result item: drive %0d error %0d",
                             out_ch.drive, out_ch.error_out);
                end
                fail_count++;
            end else begin
                want = pid_result_q.pop_front();
                if (out_ch.drive !== want.drive || out_ch.error_out !== want.error_out) begin
                    if (fail_count < 10) begin
                        $display("mismatch: drive exp %0d got %0d, error exp %0d got %0d",
                                 want.drive, out_ch.drive, want.error_out, out_ch.error_out);
                    end
                    fail_count++;
                end
            end
        end
    end

    // Guard against a hung handshake.
    initial begin : watchdog
        #10_000_000;
        $display("multi_mode_positional_pid_top_tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        int          ph, k, e, t, f, lo, hi, db, span, cur_target;
        t_dir_row    row;
        t_pid_result none;

        none.drive      = '0;
        none.error_out  = '0;
        fail_count      = 0;
        gaps_on         = 1'b1;
        hold_req        = 1'b0;
        cur_target      = 0;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.target    = '0;
        in_ch.feedback  = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = mpid_pkg::REG_MODE;
        cfg_ch.data     = '0;

        // Reset values of the predictor copy.
        pid_cfg                = '0;
        pid_cfg.mode           = mpid_pkg::MODE_PLAIN;
        pid_cfg.drive_limit    = mpid_pkg::DRIVE_LIMIT_RST;
        pid_cfg.integral_limit = mpid_pkg::INTEGRAL_LIMIT_RST;
        pid_cfg.term_limit     = mpid_pkg::TERM_LIMIT_RST;
        integ_sum              = 0;
        prev_error             = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows. After reset the gains are zero, so the drive is zero.
        add_typed(32767, -32768, 0, 65535);
        add_typed(-32768, 32767, 0, -65535);
        add_typed(5, 5, 0, 0);
        // Full proportional gain against a small drive bound.
        add_write(mpid_pkg::REG_GAIN_P, 65535);
        add_write(mpid_pkg::REG_DRIVE_LIMIT, 100);
        add_typed(32767, -32768, 100, 65535);
        add_typed(-32768, 32767, -100, -65535);
        add_write(mpid_pkg::REG_DRIVE_LIMIT, 0);
        add_typed(1000, 0, 0, 1000);
        // Plain mode around the dead band edge.
        add_write(mpid_pkg::REG_DRIVE_LIMIT, 32767);
        add_write(mpid_pkg::REG_GAIN_P, 256);
        add_write(mpid_pkg::REG_GAIN_I, 64);
        add_write(mpid_pkg::REG_GAIN_D, 128);
        add_write(mpid_pkg::REG_DEAD_BAND, 10);
        add_sample(10, 0);
        add_sample(11, 0);
        add_sample(-10, 0);
        add_sample(-11, 0);
        // Integral separation on both sides of its threshold.
        add_write(mpid_pkg::REG_MODE, mpid_pkg::MODE_SEPARATED);
        add_write(mpid_pkg::REG_INTEGRAL_LIMIT, 50);
        add_sample(40, 0);
        add_sample(60, 0);
        add_sample(50, 0);
        // Anti-windup: clipped sum and terms, sum cleared inside the band.
        add_write(mpid_pkg::REG_MODE, mpid_pkg::MODE_ANTI_WINDUP);
        add_write(mpid_pkg::REG_TERM_LIMIT, 200);
        add_write(mpid_pkg::REG_INTEGRAL_LIMIT, 300);
        add_write(mpid_pkg::REG_DEAD_BAND, 5);
        add_sample(100, 0);
        add_sample(400, 0);
        add_sample(-32768, 32767);
        add_sample(3, 0);
        add_sample(5, 0);
        add_sample(0, 0);
        // Weakened integration: only errors inside the window accumulate.
        add_write(mpid_pkg::REG_MODE, mpid_pkg::MODE_WEAKENED);
        add_write(mpid_pkg::REG_DEAD_BAND, 20);
        add_sample(10, 0);
        add_sample(20, 0);
        add_sample(-15, 0);
        add_sample(32767, -32768);
        // Zero clip bounds, then back to plain with the widest bounds.
        add_write(mpid_pkg::REG_TERM_LIMIT, 0);
        add_write(mpid_pkg::REG_INTEGRAL_LIMIT, 0);
        add_sample(1000, 0);
        add_write(mpid_pkg::REG_INTEGRAL_LIMIT, 2147483647);
        add_write(mpid_pkg::REG_TERM_LIMIT, 32767);
        add_write(mpid_pkg::REG_MODE, mpid_pkg::MODE_PLAIN);
        add_sample(0, 0);

        for (k = 0; k < dir_rows.size(); k++) begin
            row = dir_rows[k];
            if (row.kind == ROW_WRITE) write_reg(row.idx, row.data);
            else send_sample(row.tgt, row.fbk, row.typed, row.res);
        end

        // Random phases: fresh settings, then mostly steady setpoints.
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            write_reg(mpid_pkg::REG_MODE,
                      t_cfg_data'((ph < 4) ? ph : int'($urandom_range(3))));
            write_reg(mpid_pkg::REG_GAIN_P, rand_pick(512, 65535));
            write_reg(mpid_pkg::REG_GAIN_I, rand_pick(64, 65535));
            write_reg(mpid_pkg::REG_GAIN_D, rand_pick(512, 65535));
            write_reg(mpid_pkg::REG_DRIVE_LIMIT, rand_pick(32767, 32767));
            write_reg(mpid_pkg::REG_DEAD_BAND, rand_pick(200, 65535));
            write_reg(mpid_pkg::REG_INTEGRAL_LIMIT, rand_pick(20000, 2147483647));
            write_reg(mpid_pkg::REG_TERM_LIMIT, rand_pick(32767, 32767));
            gaps_on = (ph != 5);
            if (ph == 2) hold_req = 1'b1;
            db = pid_cfg.dead_band;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(3) == 0) cur_target = int'($urandom_range(65535)) - 32768;
                t = cur_target;
                case ($urandom_range(3))
                    0: begin
                        t = int'($urandom_range(65535)) - 32768;
                        e = t - (int'($urandom_range(65535)) - 32768);
                    end
                    1: begin
                        span = (db + 2 > 65535) ? 65535 : db + 2;
                        e = int'($urandom_range(2 * span)) - span;
                    end
                    2: begin
                        e = db + int'($urandom_range(2)) - 1;
                        if (e > 65535) e = 65535;
                        if ($urandom_range(1) == 1) e = -e;
                    end
                    default: e = int'($urandom_range(600)) - 300;
                endcase
                lo = (e - 32768 > -32768) ? e - 32768 : -32768;
                hi = (e + 32767 < 32767) ? e + 32767 : 32767;
                if (t < lo || t > hi) t = lo + int'($urandom_range(hi - lo));
                f = t - e;
                send_sample(t_sample'(t), t_sample'(f), 1'b0, none);
            end
        end

        // Drive the integral up at full error, then back down past zero.
        gaps_on = 1'b0;
        write_reg(mpid_pkg::REG_MODE, t_cfg_data'(mpid_pkg::MODE_PLAIN));
        write_reg(mpid_pkg::REG_DEAD_BAND, '0);
        write_reg(mpid_pkg::REG_GAIN_P, '0);
        write_reg(mpid_pkg::REG_GAIN_I, t_cfg_data'(1));
        write_reg(mpid_pkg::REG_GAIN_D, '0);
        write_reg(mpid_pkg::REG_DRIVE_LIMIT, t_cfg_data'(32767));
        repeat (WINDUP_ITEMS) send_sample(t_sample'(32767), t_sample'(-32768), 1'b0, none);
        // A large P term opposes the integral while it winds back down.
        write_reg(mpid_pkg::REG_GAIN_P, t_cfg_data'(32768));
        repeat (2 * WINDUP_ITEMS)
            send_sample(t_sample'(-32768), t_sample'(32767), 1'b0, none);
        repeat (4) send_sample(t_sample'(32767), t_sample'(-32768), 1'b0, none);
        gaps_on = 1'b1;

        wait_results_done();
        repeat (SETTLE) @(posedge i_clk);
        fail_count += pid_result_q.size();
        if (fail_count == 0) begin
            $display("multi_mode_positional_pid_top_tb OK");
        end else begin
            $display("multi_mode_positional_pid_top_tb NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/mpid_pkg.sv
rtl/core/mpid_if.sv
rtl/core/mpid_state.sv
rtl/core/mpid_mult.sv
rtl/core/mpid_scale.sv
rtl/core/mpid_sum.sv
rtl/core/multi_mode_positional_pid_top.sv
rtl/core/mpid_checker.sv
dv/multi_mode_positional_pid_top_tb.sv
